/* rtl/core/tpmq_pkg.sv */
`default_nettype none

package tpmq_pkg;

    localparam int NODE_W   = 10;
    localparam int NODES    = 1 << NODE_W;
    localparam int WEIGHT_W = 31;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/tpmq_ram.sv */
`default_nettype none

module tpmq_ram #(
    parameter int W     = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [W-1:0]  rdata_a,
    output logic      [W-1:0]  rdata_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* rtl/core/tpmq_ctrl.sv */
`default_nettype none

module tpmq_ctrl #(
    parameter int LEVELS = 10,
    parameter int LW     = 4,
    parameter int AW     = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [tpmq_pkg::OP_W-1:0]     opcode,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   node,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   parent,
    input  wire logic [tpmq_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   depth,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   other_node,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   node_count,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [tpmq_pkg::WEIGHT_W-1:0] path_max,
    output logic                               tbl_we,
    output logic      [AW-1:0]                 tbl_waddr,
    output logic      [tpmq_pkg::NODE_W-1:0]   anc_wdata,
    output logic      [tpmq_pkg::WEIGHT_W-1:0] max_wdata,
    output logic      [AW-1:0]                 tbl_raddr_a,
    output logic      [AW-1:0]                 tbl_raddr_b,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   anc_rdata_a,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   anc_rdata_b,
    input  wire logic [tpmq_pkg::WEIGHT_W-1:0] max_rdata_a,
    input  wire logic [tpmq_pkg::WEIGHT_W-1:0] max_rdata_b,
    output logic                               dep_we,
    output logic      [tpmq_pkg::NODE_W-1:0]   dep_waddr,
    output logic      [tpmq_pkg::NODE_W-1:0]   dep_wdata,
    output logic      [tpmq_pkg::NODE_W-1:0]   dep_raddr_a,
    output logic      [tpmq_pkg::NODE_W-1:0]   dep_raddr_b,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   dep_rdata_a,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   dep_rdata_b
);

    localparam int NW = tpmq_pkg::NODE_W;
    localparam int WW = tpmq_pkg::WEIGHT_W;
    localparam int SW = 5;

    localparam logic [SW-1:0] ST_IDLE  = 5'd0;
    localparam logic [SW-1:0] ST_B_RD  = 5'd1;
    localparam logic [SW-1:0] ST_B_MID = 5'd2;
    localparam logic [SW-1:0] ST_B_WR  = 5'd3;
    localparam logic [SW-1:0] ST_Q_RD  = 5'd4;
    localparam logic [SW-1:0] ST_Q_ORD = 5'd5;
    localparam logic [SW-1:0] ST_L_RD  = 5'd6;
    localparam logic [SW-1:0] ST_L_DEP = 5'd7;
    localparam logic [SW-1:0] ST_L_CMP = 5'd8;
    localparam logic [SW-1:0] ST_E_CHK = 5'd9;
    localparam logic [SW-1:0] ST_J_RD  = 5'd10;
    localparam logic [SW-1:0] ST_J_CMP = 5'd11;
    localparam logic [SW-1:0] ST_J_ACC = 5'd12;
    localparam logic [SW-1:0] ST_F_RD  = 5'd13;
    localparam logic [SW-1:0] ST_F_CMP = 5'd14;
    localparam logic [SW-1:0] ST_F_ACC = 5'd15;
    localparam logic [SW-1:0] ST_RES   = 5'd16;

    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS);

    logic [SW-1:0] state_reg, state_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] u_reg, u_next;
    logic [NW-1:0] v_reg, v_next;
    logic [NW-1:0] dv_reg, dv_next;
    logic [NW-1:0] up_reg, up_next;
    logic [WW-1:0] tmp_reg, tmp_next;
    logic [WW-1:0] best_reg, best_next;
    logic          za_reg, za_next;
    logic          zb_reg, zb_next;
    logic          res_valid_reg, res_valid_next;
    logic [WW-1:0] res_data_reg, res_data_next;

    logic [NW-1:0] anc_a, anc_b, dep_a, dep_b;
    logic [WW-1:0] max_a, max_b;
    logic [LW-1:0] r_lvl, w_lvl;
    logic [NW-1:0] ra_node, rb_node, w_node;
    logic [WW-1:0] cmp_a, cmp_b, cmp_max;
    logic          res_load;

    // node 0 is the null ancestor: every field reads as zero
    assign anc_a = za_reg ? '0 : anc_rdata_a;
    assign anc_b = zb_reg ? '0 : anc_rdata_b;
    assign max_a = za_reg ? '0 : max_rdata_a;
    assign max_b = zb_reg ? '0 : max_rdata_b;
    assign dep_a = za_reg ? '0 : dep_rdata_a;
    assign dep_b = zb_reg ? '0 : dep_rdata_b;

    // shared max unit
    assign cmp_max = (cmp_a > cmp_b) ? cmp_a : cmp_b;

    assign tbl_waddr   = {w_lvl, w_node};
    assign tbl_raddr_a = {r_lvl, ra_node};
    assign tbl_raddr_b = {r_lvl, rb_node};
    assign dep_waddr   = node;
    assign dep_wdata   = depth;
    assign dep_raddr_a = ra_node;
    assign dep_raddr_b = rb_node;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign path_max     = res_data_reg;

    assign res_load       = (state_reg == ST_RES) && (!res_valid_reg || !result_stall);
    assign res_valid_next = res_load || (res_valid_reg && result_stall);
    assign res_data_next  = res_load ? best_reg : res_data_reg;
    assign za_next        = (ra_node == '0);
    assign zb_next        = (rb_node == '0);

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        dv_next    = dv_reg;
        up_next    = up_reg;
        tmp_next   = tmp_reg;
        best_next  = best_reg;
        tbl_we     = 1'b0;
        dep_we     = 1'b0;
        w_lvl      = lvl_reg;
        w_node     = idx_reg;
        anc_wdata  = anc_a;
        max_wdata  = cmp_max;
        r_lvl      = lvl_reg;
        ra_node    = u_reg;
        rb_node    = v_reg;
        cmp_a      = best_reg;
        cmp_b      = tmp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (opcode)
                        tpmq_pkg::OP_LOAD:
                        begin
                            if (node != '0)
                            begin
                                tbl_we    = 1'b1;
                                dep_we    = 1'b1;
                                w_lvl     = '0;
                                w_node    = node;
                                anc_wdata = parent;
                                max_wdata = weight;
                            end
                        end
                        tpmq_pkg::OP_BUILD:
                        begin
                            if (node_count != '0)
                            begin
                                lvl_next   = LW'(1);
                                idx_next   = NW'(1);
                                state_next = ST_B_RD;
                            end
                        end
                        tpmq_pkg::OP_QUERY:
                        begin
                            u_next     = node;
                            v_next     = other_node;
                            state_next = ST_Q_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_B_RD:
            begin
                r_lvl      = lvl_reg - LW'(1);
                ra_node    = idx_reg;
                state_next = ST_B_MID;
            end
            ST_B_MID:
            begin
                r_lvl      = lvl_reg - LW'(1);
                ra_node    = anc_a;
                tmp_next   = max_a;
                state_next = ST_B_WR;
            end
            ST_B_WR:
            begin
                cmp_a      = tmp_reg;
                cmp_b      = max_a;
                tbl_we     = 1'b1;
                state_next = ST_B_RD;
                if (idx_reg == node_count)
                begin
                    idx_next = NW'(1);
                    if (lvl_reg == LVL_TOP)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + NW'(1);
                end
            end
            ST_Q_RD:
            begin
                state_next = ST_Q_ORD;
            end
            ST_Q_ORD:
            begin
                // deeper node goes to u
                if (dep_a < dep_b)
                begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    dv_next = dep_a;
                end
                else
                begin
                    dv_next = dep_b;
                end
                lvl_next   = LVL_TOP;
                best_next  = '0;
                state_next = ST_L_RD;
            end
            ST_L_RD:
            begin
                state_next = ST_L_DEP;
            end
            ST_L_DEP:
            begin
                up_next    = anc_a;
                tmp_next   = max_a;
                ra_node    = anc_a;
                state_next = ST_L_CMP;
            end
            ST_L_CMP:
            begin
                if (dep_a >= dv_reg)
                begin
                    best_next = cmp_max;
                    u_next    = up_reg;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_E_CHK;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_L_RD;
                end
            end
            ST_E_CHK:
            begin
                if (u_reg == v_reg)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_J_RD;
                end
            end
            ST_J_RD:
            begin
                state_next = ST_J_CMP;
            end
            ST_J_CMP:
            begin
                cmp_a = max_a;
                cmp_b = max_b;
                if (anc_a != anc_b)
                begin
                    tmp_next   = cmp_max;
                    u_next     = anc_a;
                    v_next     = anc_b;
                    state_next = ST_J_ACC;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_F_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_J_RD;
                end
            end
            ST_J_ACC:
            begin
                best_next = cmp_max;
                if (lvl_reg == '0)
                begin
                    state_next = ST_F_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_J_RD;
                end
            end
            ST_F_RD:
            begin
                r_lvl      = '0;
                state_next = ST_F_CMP;
            end
            ST_F_CMP:
            begin
                cmp_a      = max_a;
                cmp_b      = max_b;
                tmp_next   = cmp_max;
                state_next = ST_F_ACC;
            end
            ST_F_ACC:
            begin
                best_next  = cmp_max;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        dv_reg       <= dv_next;
        up_reg       <= up_next;
        tmp_reg      <= tmp_next;
        best_reg     <= best_next;
        za_reg       <= za_next;
        zb_reg       <= zb_next;
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/tree_path_max_query_unit.sv */
// Channel   Handshake                  Payload
// item      item_valid / item_stall    opcode, node, parent, weight, depth, other_node
// result    result_valid / result_stall path_max
// config    cfg_write                  cfg_data (node_count)
//
// Load: a table write that does not stall the input. Build: a read, a mid and a write step per
// node per level, a walk that uses only read port a of the tables.
// Query: depth ordering, lifting over all levels, a meet check, joint lifting and a final step;
// each lifting level is a table read, a depth read and a step of the shared max unit.
// The result register frees the sequencer while a result is stalled.
// Reset clears control only; tables hold garbage until loaded and built.
`default_nettype none

module tree_path_max_query_unit #(
    parameter int LEVELS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [tpmq_pkg::OP_W-1:0]     opcode,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   node,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   parent,
    input  wire logic [tpmq_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   depth,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   other_node,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [tpmq_pkg::WEIGHT_W-1:0] path_max,
    input  wire logic                          cfg_write,
    input  wire logic [tpmq_pkg::NODE_W-1:0]   cfg_data
);

    localparam int NW    = tpmq_pkg::NODE_W;
    localparam int WW    = tpmq_pkg::WEIGHT_W;
    localparam int LW    = $clog2(LEVELS + 1);
    localparam int AW    = LW + NW;
    localparam int TDEPTH = (LEVELS + 1) * tpmq_pkg::NODES;

    logic [NW-1:0] node_count_reg, node_count_next;

    logic          tbl_we, dep_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr_a, tbl_raddr_b;
    logic [NW-1:0] anc_wdata, anc_rdata_a, anc_rdata_b;
    logic [WW-1:0] max_wdata, max_rdata_a, max_rdata_b;
    logic [NW-1:0] dep_waddr, dep_wdata, dep_raddr_a, dep_raddr_b;
    logic [NW-1:0] dep_rdata_a, dep_rdata_b;

    assign node_count_next = cfg_write ? cfg_data : node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NW'(1);
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    tpmq_ram #(
        .W     (NW),
        .DEPTH (TDEPTH),
        .AW    (AW)
    ) u_anc_ram (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (anc_wdata),
        .raddr_a (tbl_raddr_a),
        .raddr_b (tbl_raddr_b),
        .rdata_a (anc_rdata_a),
        .rdata_b (anc_rdata_b)
    );

    tpmq_ram #(
        .W     (WW),
        .DEPTH (TDEPTH),
        .AW    (AW)
    ) u_max_ram (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (max_wdata),
        .raddr_a (tbl_raddr_a),
        .raddr_b (tbl_raddr_b),
        .rdata_a (max_rdata_a),
        .rdata_b (max_rdata_b)
    );

    tpmq_ram #(
        .W     (NW),
        .DEPTH (tpmq_pkg::NODES),
        .AW    (NW)
    ) u_dep_ram (
        .clk     (clk),
        .we      (dep_we),
        .waddr   (dep_waddr),
        .wdata   (dep_wdata),
        .raddr_a (dep_raddr_a),
        .raddr_b (dep_raddr_b),
        .rdata_a (dep_rdata_a),
        .rdata_b (dep_rdata_b)
    );

    tpmq_ctrl #(
        .LEVELS (LEVELS),
        .LW     (LW),
        .AW     (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .node         (node),
        .parent       (parent),
        .weight       (weight),
        .depth        (depth),
        .other_node   (other_node),
        .node_count   (node_count_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .path_max     (path_max),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .anc_wdata    (anc_wdata),
        .max_wdata    (max_wdata),
        .tbl_raddr_a  (tbl_raddr_a),
        .tbl_raddr_b  (tbl_raddr_b),
        .anc_rdata_a  (anc_rdata_a),
        .anc_rdata_b  (anc_rdata_b),
        .max_rdata_a  (max_rdata_a),
        .max_rdata_b  (max_rdata_b),
        .dep_we       (dep_we),
        .dep_waddr    (dep_waddr),
        .dep_wdata    (dep_wdata),
        .dep_raddr_a  (dep_raddr_a),
        .dep_raddr_b  (dep_raddr_b),
        .dep_rdata_a  (dep_rdata_a),
        .dep_rdata_b  (dep_rdata_b)
    );

endmodule

`default_nettype wire

/* rtl/core/tpmq_checker.sv */
`default_nettype none

module tpmq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_stall,
    input wire logic [tpmq_pkg::OP_W-1:0]     opcode,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic [tpmq_pkg::WEIGHT_W-1:0] path_max
);

    logic item_take;

    assign item_take = item_valid && !item_stall;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(path_max))
        else $error("stalled result changed");

    // a query occupies the sequencer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (opcode == tpmq_pkg::OP_QUERY) |=> item_stall)
        else $error("query item did not block the input");

    // a load completes in its accept cycle
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (opcode == tpmq_pkg::OP_LOAD) |=> !item_stall)
        else $error("load item blocked the input");

    // a new result only comes out of a busy sequencer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a query in flight");

endmodule

bind tree_path_max_query_unit tpmq_checker u_tpmq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .path_max     (path_max)
);

`default_nettype wire
